// ----- src/rtzb_pkg.sv -----
// shared types and constants of the tile rasterizer with depth store
`default_nettype none
package rtzb_pkg;

	localparam int XY_W   = 16;
	localparam int Z_W    = 24;
	localparam int W_W    = 16;
	localparam int PIX_W  = 3;
	localparam int E_W    = 35;
	localparam int N_W    = 62;
	localparam int PROD_W = 59;
	localparam int DIVD_W = 60;
	localparam int Q_W    = 24;
	localparam int NB_W   = 5;
	localparam int DSH    = Q_W - 1;

	localparam logic OP_RASTER = 1'b0;
	localparam logic OP_CLEAR  = 1'b1;

	localparam logic signed [Z_W-1:0] DEPTH_MIN = 24'sh800000;
	localparam logic signed [Z_W-1:0] DEPTH_MAX = 24'sh7fffff;

	localparam logic signed [E_W-1:0] AREA_MIN_OK = 35'sd2;
	localparam logic [E_W-1:0]        AREA_SUB    = 35'd256;
	localparam logic [W_W-1:0]        WEIGHT_SAT  = 16'hffff;

	localparam logic [NB_W-1:0] NB_DEPTH  = 5'd24;
	localparam logic [NB_W-1:0] NB_WEIGHT = 5'd16;

	typedef struct packed {
		logic            start;
		logic [NB_W-1:0] nbits;
	} div_req_t;

	typedef struct packed {
		logic [PIX_W-1:0]       pix_x;
		logic [PIX_W-1:0]       pix_y;
		logic [W_W-1:0]         weight_a;
		logic [W_W-1:0]         weight_b;
		logic [W_W-1:0]         weight_c;
		logic signed [Z_W-1:0]  frag_depth;
		logic                   last;
	} frag_t;

endpackage
`default_nettype wire

// ----- src/rtzb_if.sv -----
// request and fragment channel interfaces
`default_nettype none
interface rtzb_cmd_if;
	import rtzb_pkg::*;
	logic                   valid;
	logic                   ready;
	logic                   op;
	logic signed [XY_W-1:0] v0_x;
	logic signed [XY_W-1:0] v0_y;
	logic signed [Z_W-1:0]  v0_z;
	logic signed [XY_W-1:0] v1_x;
	logic signed [XY_W-1:0] v1_y;
	logic signed [Z_W-1:0]  v1_z;
	logic signed [XY_W-1:0] v2_x;
	logic signed [XY_W-1:0] v2_y;
	logic signed [Z_W-1:0]  v2_z;
	modport source (output valid, op, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, input ready);
	modport sink (input valid, op, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z,
		v2_x, v2_y, v2_z, output ready);
endinterface

interface rtzb_frag_if;
	import rtzb_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PIX_W-1:0]      pix_x;
	logic [PIX_W-1:0]      pix_y;
	logic [W_W-1:0]        weight_a;
	logic [W_W-1:0]        weight_b;
	logic [W_W-1:0]        weight_c;
	logic signed [Z_W-1:0] frag_depth;
	logic                  last;
	modport source (output valid, pix_x, pix_y, weight_a, weight_b, weight_c,
		frag_depth, last, input ready);
	modport sink (input valid, pix_x, pix_y, weight_a, weight_b, weight_c,
		frag_depth, last, output ready);
endinterface
`default_nettype wire

// ----- src/rtzb_div.sv -----
// restoring divider, one quotient bit per cycle, quotient known to fit nbits
`default_nettype none
module rtzb_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  rtzb_pkg::div_req_t        req,
	input  logic [rtzb_pkg::DIVD_W-1:0] dividend,
	input  logic [rtzb_pkg::E_W-1:0]  divisor,
	output logic                      done,
	output logic [rtzb_pkg::Q_W-1:0]  quot
);
	import rtzb_pkg::*;

	logic [DIVD_W-1:0] rem_q;
	logic [DIVD_W-1:0] ds_q;
	logic [Q_W-1:0]    q_q;
	logic [NB_W-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	assign ge   = rem_q >= ds_q;
	assign done = done_q;
	assign quot = q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - NB_W'(1);
				if (cnt_q == NB_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= dividend;
			// divisor aligned to the top quotient bit
			ds_q  <= DIVD_W'({{(DIVD_W-E_W){1'b0}}, divisor} << (req.nbits - NB_W'(1)));
			q_q   <= '0;
		end else if (busy_q) begin
			if (ge)
				rem_q <= rem_q - ds_q;
			q_q  <= {q_q[Q_W-2:0], ge};
			ds_q <= ds_q >> 1;
		end
	end

endmodule
`default_nettype wire

// ----- src/triangle_tile_rasterizer_zbuffer.sv -----
// tile rasterizer with depth store: top level
// Requests arrive on cmd (valid/ready). op clear resets the 64-entry depth
// store to the most negative depth and emits nothing. op rasterize takes
// three screen-space vertices; the clamped bounding box is scanned column
// by column, rows inner, and every covered pixel that passes the strict
// depth test updates the store and is sent on frag with its three unsigned
// Q1.15 weights and depth; last marks the final fragment.
// One request is processed at a time: cmd.ready is high only while idle.
// Setup computes the triangle area and the clamped box. Each box pixel then
// runs multiply-accumulate on the single shared 35x24 multiplier, the edge
// check, the depth division, the store read and compare, for a passing
// pixel up to three weight divisions and the emit, and the step; the
// bit-serial divider dominates the time per pixel.
// Fragments are held one back so last can be set, then pass through an
// output register; a stalled receiver stops the scan only when both the
// held fragment and the output register are full.
// Reset empties the store (all entries read as the most negative depth),
// the output register and the sequencer.
`default_nettype none
module triangle_tile_rasterizer_zbuffer #(
	parameter int TILE_WIDTH  = 8,
	parameter int TILE_HEIGHT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	rtzb_cmd_if.sink    cmd,
	rtzb_frag_if.source frag
);
	import rtzb_pkg::*;

	localparam int NPIX = TILE_WIDTH * TILE_HEIGHT;
	localparam int XW   = (TILE_WIDTH > 1) ? $clog2(TILE_WIDTH) : 1;
	localparam int YW   = (TILE_HEIGHT > 1) ? $clog2(TILE_HEIGHT) : 1;
	localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
	localparam logic signed [XY_W:0] XMAX = (XY_W+1)'((TILE_WIDTH - 1) * 16);
	localparam logic signed [XY_W:0] YMAX = (XY_W+1)'((TILE_HEIGHT - 1) * 16);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_BBOX   = 4'd1;
	localparam logic [3:0] ST_MULT   = 4'd2;
	localparam logic [3:0] ST_CHECK  = 4'd3;
	localparam logic [3:0] ST_DDIV   = 4'd4;
	localparam logic [3:0] ST_RD     = 4'd5;
	localparam logic [3:0] ST_CMP    = 4'd6;
	localparam logic [3:0] ST_WSTART = 4'd7;
	localparam logic [3:0] ST_WWAIT  = 4'd8;
	localparam logic [3:0] ST_EMIT   = 4'd9;
	localparam logic [3:0] ST_NEXT   = 4'd10;
	localparam logic [3:0] ST_FLUSH  = 4'd11;

	// multiply-accumulate steps
	localparam logic [3:0] SP_E0P = 4'd0;
	localparam logic [3:0] SP_E0M = 4'd1;
	localparam logic [3:0] SP_E1P = 4'd2;
	localparam logic [3:0] SP_E1M = 4'd3;
	localparam logic [3:0] SP_E2P = 4'd4;
	localparam logic [3:0] SP_E2M = 4'd5;
	localparam logic [3:0] SP_Z0  = 4'd6;
	localparam logic [3:0] SP_Z1  = 4'd7;
	localparam logic [3:0] SP_Z2  = 4'd8;

	localparam logic [1:0] K_LAST = 2'd2;

	logic [3:0]             state_q;
	logic [3:0]             s_q;
	logic                   area_mode_q;
	logic [1:0]             k_q;
	logic [XW-1:0]          x_q, xend_q;
	logic [YW-1:0]          y_q, y0_q, y1_q;
	logic [NPIX-1:0]        vld_q;
	logic                   pend_v_q;
	logic                   out_v_q;

	logic signed [XY_W-1:0] vx_q [3];
	logic signed [XY_W-1:0] vy_q [3];
	logic signed [Z_W-1:0]  vz_q [3];
	logic signed [E_W-1:0]  e_q [3];
	logic signed [N_W-1:0]  n_q;
	logic [E_W-1:0]         area_q;
	logic signed [Z_W-1:0]  d_q;
	logic [W_W-1:0]         w_q [3];
	logic signed [PROD_W-1:0] prod_q;
	frag_t                  pend_q;
	frag_t                  out_q;

	logic signed [Z_W-1:0]  mem [NPIX];
	logic signed [Z_W-1:0]  rd_q;
	logic                   rdv_q;

	logic                   cmd_acc;
	logic                   out_free;
	logic                   out_load;
	frag_t                  out_next;
	logic [3:0]             s_last;
	logic [3:0]             acc_step;
	logic signed [XY_W:0]   ox, oy;
	logic signed [XY_W:0]   dx [3];
	logic signed [XY_W:0]   dy [3];
	logic signed [E_W-1:0]  mul_a;
	logic signed [Z_W-1:0]  mul_b;
	logic [AW-1:0]          addr_c;
	logic signed [Z_W-1:0]  stored;
	logic                   we_c;
	logic signed [N_W-1:0]  lim;
	logic                   d_hi, d_lo;
	logic signed [E_W-1:0]  ek;
	logic                   w_sat;
	div_req_t               div_req;
	logic [DIVD_W-1:0]      div_dvd;
	logic                   div_done;
	logic [Q_W-1:0]         div_quot;
	frag_t                  new_frag;

	logic signed [XY_W-1:0] minx, maxx, miny, maxy;
	logic [XY_W-6:0]        x0v, y0v;
	logic signed [XY_W:0]   mxx_c, mxy_c, x1v, y1v;
	logic                   box_empty;

	assign cmd_acc   = cmd.valid && cmd.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign out_free  = !out_v_q || frag.ready;
	// held fragment moves to the output register
	assign out_load  = pend_v_q && out_free
		&& ((state_q == ST_EMIT) || (state_q == ST_FLUSH));

	always_comb begin
		out_next = pend_q;
		if (state_q == ST_FLUSH)
			out_next.last = 1'b1;
	end

	// origin of the edge functions: vertex 0 for the area, else the pixel
	assign ox = area_mode_q ? {vx_q[0][XY_W-1], vx_q[0]}
		: $signed({{(XY_W+1-XW-4){1'b0}}, x_q, 4'b0});
	assign oy = area_mode_q ? {vy_q[0][XY_W-1], vy_q[0]}
		: $signed({{(XY_W+1-YW-4){1'b0}}, y_q, 4'b0});

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dx[i] = {vx_q[i][XY_W-1], vx_q[i]} - ox;
			dy[i] = {vy_q[i][XY_W-1], vy_q[i]} - oy;
		end
	end

	assign s_last   = area_mode_q ? SP_E0M : SP_Z2;
	assign acc_step = s_q - 4'd1;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (s_q)
			SP_E0P: begin mul_a = E_W'(dx[1]); mul_b = Z_W'(dy[2]); end
			SP_E0M: begin mul_a = E_W'(dx[2]); mul_b = Z_W'(dy[1]); end
			SP_E1P: begin mul_a = E_W'(dx[2]); mul_b = Z_W'(dy[0]); end
			SP_E1M: begin mul_a = E_W'(dx[0]); mul_b = Z_W'(dy[2]); end
			SP_E2P: begin mul_a = E_W'(dx[0]); mul_b = Z_W'(dy[1]); end
			SP_E2M: begin mul_a = E_W'(dx[1]); mul_b = Z_W'(dy[0]); end
			SP_Z0:  begin mul_a = e_q[0]; mul_b = vz_q[0]; end
			SP_Z1:  begin mul_a = e_q[1]; mul_b = vz_q[1]; end
			SP_Z2:  begin mul_a = e_q[2]; mul_b = vz_q[2]; end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	// bounding box, clamped to the tile
	always_comb begin
		minx = vx_q[0]; maxx = vx_q[0];
		miny = vy_q[0]; maxy = vy_q[0];
		for (int i = 1; i < 3; i++) begin
			if (vx_q[i] < minx) minx = vx_q[i];
			if (vx_q[i] > maxx) maxx = vx_q[i];
			if (vy_q[i] < miny) miny = vy_q[i];
			if (vy_q[i] > maxy) maxy = vy_q[i];
		end
		x0v   = (minx < 0) ? '0 : minx[XY_W-2:4];
		y0v   = (miny < 0) ? '0 : miny[XY_W-2:4];
		mxx_c = ({maxx[XY_W-1], maxx} > XMAX) ? XMAX : {maxx[XY_W-1], maxx};
		mxy_c = ({maxy[XY_W-1], maxy} > YMAX) ? YMAX : {maxy[XY_W-1], maxy};
		// truncate toward zero
		x1v   = (mxx_c >= 0) ? (mxx_c >>> 4) : -((-mxx_c) >>> 4);
		y1v   = (mxy_c >= 0) ? (mxy_c >>> 4) : -((-mxy_c) >>> 4);
		box_empty = (x1v < 0) || (y1v < 0)
			|| ($signed({6'b0, x0v}) > x1v) || ($signed({6'b0, y0v}) > y1v);
	end

	assign addr_c = AW'(AW'(x_q) + AW'(y_q) * AW'(TILE_WIDTH));
	assign stored = rdv_q ? rd_q : DEPTH_MIN;
	assign we_c   = (state_q == ST_CMP) && (stored < d_q);

	assign lim  = $signed({{(N_W-E_W-DSH){1'b0}}, area_q, {DSH{1'b0}}});
	assign d_hi = n_q >= lim;
	assign d_lo = n_q < -lim;

	always_comb begin
		ek = e_q[0];
		unique case (k_q)
			2'd0: ek = e_q[0];
			2'd1: ek = e_q[1];
			default: ek = e_q[2];
		endcase
	end
	assign w_sat = {1'b0, ek} >= {area_q, 1'b0};

	always_comb begin
		div_req.start = 1'b0;
		div_req.nbits = NB_DEPTH;
		div_dvd       = DIVD_W'(n_q + lim);
		if (state_q == ST_CHECK && !e_q[0][E_W-1] && !e_q[1][E_W-1]
			&& !e_q[2][E_W-1] && !d_hi && !d_lo) begin
			div_req.start = 1'b1;
		end else if (state_q == ST_WSTART && !w_sat) begin
			div_req.start = 1'b1;
			div_req.nbits = NB_WEIGHT;
			div_dvd       = DIVD_W'({ek, 15'b0});
		end
	end

	rtzb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_dvd),
		.divisor  (area_q),
		.done     (div_done),
		.quot     (div_quot)
	);

	always_comb begin
		new_frag.pix_x      = PIX_W'(x_q);
		new_frag.pix_y      = PIX_W'(y_q);
		new_frag.weight_a   = w_q[0];
		new_frag.weight_b   = w_q[1];
		new_frag.weight_c   = w_q[2];
		new_frag.frag_depth = d_q;
		new_frag.last       = 1'b0;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			s_q         <= '0;
			area_mode_q <= 1'b0;
			k_q         <= '0;
			x_q         <= '0;
			xend_q      <= '0;
			y_q         <= '0;
			y0_q        <= '0;
			y1_q        <= '0;
			vld_q       <= '0;
			pend_v_q    <= 1'b0;
			out_v_q     <= 1'b0;
		end else begin
			if (out_load)
				out_v_q <= 1'b1;
			else if (frag.ready)
				out_v_q <= 1'b0;
			if (we_c)
				vld_q[addr_c] <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_acc) begin
						if (cmd.op == OP_CLEAR) begin
							vld_q <= '0;
						end else begin
							s_q         <= '0;
							area_mode_q <= 1'b1;
							state_q     <= ST_MULT;
						end
					end
				end
				ST_MULT: begin
					s_q <= s_q + 4'd1;
					if (s_q == s_last + 4'd1)
						state_q <= area_mode_q ? ST_BBOX : ST_CHECK;
				end
				ST_BBOX: begin
					area_mode_q <= 1'b0;
					if (box_empty) begin
						state_q <= ST_FLUSH;
					end else begin
						x_q     <= XW'(x0v);
						xend_q  <= XW'(x1v);
						y_q     <= YW'(y0v);
						y0_q    <= YW'(y0v);
						y1_q    <= YW'(y1v);
						s_q     <= '0;
						state_q <= ST_MULT;
					end
				end
				ST_CHECK: begin
					priority if (e_q[0][E_W-1] || e_q[1][E_W-1] || e_q[2][E_W-1])
						state_q <= ST_NEXT;
					else if (d_hi || d_lo)
						state_q <= ST_RD;
					else
						state_q <= ST_DDIV;
				end
				ST_DDIV: begin
					if (div_done)
						state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_CMP;
				ST_CMP: begin
					k_q     <= '0;
					state_q <= we_c ? ST_WSTART : ST_NEXT;
				end
				ST_WSTART: begin
					if (!w_sat)
						state_q <= ST_WWAIT;
					else if (k_q == K_LAST)
						state_q <= ST_EMIT;
					else
						k_q <= k_q + 2'd1;
				end
				ST_WWAIT: begin
					if (div_done) begin
						if (k_q == K_LAST) begin
							state_q <= ST_EMIT;
						end else begin
							k_q     <= k_q + 2'd1;
							state_q <= ST_WSTART;
						end
					end
				end
				ST_EMIT: begin
					if (!pend_v_q) begin
						pend_v_q <= 1'b1;
						state_q  <= ST_NEXT;
					end else if (out_free) begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					s_q <= '0;
					if (y_q == y1_q) begin
						if (x_q == xend_q) begin
							state_q <= ST_FLUSH;
						end else begin
							x_q     <= x_q + XW'(1);
							y_q     <= y0_q;
							state_q <= ST_MULT;
						end
					end else begin
						y_q     <= y_q + YW'(1);
						state_q <= ST_MULT;
					end
				end
				ST_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						pend_v_q <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			vx_q[0] <= cmd.v0_x; vy_q[0] <= cmd.v0_y; vz_q[0] <= cmd.v0_z;
			vx_q[1] <= cmd.v1_x; vy_q[1] <= cmd.v1_y; vz_q[1] <= cmd.v1_z;
			vx_q[2] <= cmd.v2_x; vy_q[2] <= cmd.v2_y; vz_q[2] <= cmd.v2_z;
		end
		prod_q <= mul_a * mul_b;
		if (state_q == ST_MULT && s_q != '0) begin
			unique case (acc_step)
				SP_E0P: e_q[0] <= E_W'(prod_q);
				SP_E0M: e_q[0] <= e_q[0] - E_W'(prod_q);
				SP_E1P: e_q[1] <= E_W'(prod_q);
				SP_E1M: e_q[1] <= e_q[1] - E_W'(prod_q);
				SP_E2P: e_q[2] <= E_W'(prod_q);
				SP_E2M: e_q[2] <= e_q[2] - E_W'(prod_q);
				SP_Z0:  n_q <= N_W'(prod_q);
				SP_Z1:  n_q <= n_q + N_W'(prod_q);
				SP_Z2:  n_q <= n_q + N_W'(prod_q);
				default: n_q <= n_q;
			endcase
		end
		if (state_q == ST_BBOX)
			area_q <= (e_q[0] <= AREA_MIN_OK) ? AREA_SUB : E_W'(e_q[0]);
		if (state_q == ST_CHECK) begin
			if (d_hi)
				d_q <= DEPTH_MAX;
			else if (d_lo)
				d_q <= DEPTH_MIN;
		end
		// quotient is offset by half the depth range
		if (state_q == ST_DDIV && div_done)
			d_q <= {~div_quot[Q_W-1], div_quot[Q_W-2:0]};
		if (state_q == ST_WSTART && w_sat)
			w_q[k_q] <= WEIGHT_SAT;
		if (state_q == ST_WWAIT && div_done)
			w_q[k_q] <= div_quot[W_W-1:0];
		if (state_q == ST_EMIT && (!pend_v_q || out_free))
			pend_q <= new_frag;
		if (out_load)
			out_q <= out_next;
	end

	// depth store
	always_ff @(posedge clk) begin
		if (we_c)
			mem[addr_c] <= d_q;
		rd_q  <= mem[addr_c];
		rdv_q <= vld_q[addr_c];
	end

	assign frag.valid      = out_v_q;
	assign frag.pix_x      = out_q.pix_x;
	assign frag.pix_y      = out_q.pix_y;
	assign frag.weight_a   = out_q.weight_a;
	assign frag.weight_b   = out_q.weight_b;
	assign frag.weight_c   = out_q.weight_c;
	assign frag.frag_depth = out_q.frag_depth;
	assign frag.last       = out_q.last;

	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !pend_v_q)
		else $error("held fragment left behind at idle");

	a_frag_in_tile: assert property (@(posedge clk) disable iff (!arst_n)
		frag.valid |-> (frag.pix_x < TILE_WIDTH) && (frag.pix_y < TILE_HEIGHT))
		else $error("fragment outside tile");

	a_write_marks: assert property (@(posedge clk) disable iff (!arst_n)
		we_c |=> vld_q[$past(addr_c)])
		else $error("store write not marked valid");

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_acc && cmd.op == OP_CLEAR |=> vld_q == '0)
		else $error("clear left valid entries");

endmodule
`default_nettype wire
